@@ hw/rtl/bst_pkg.sv @@
// ----------------------------------------------------------------------------
// bst_pkg: shared types and constants of the binary search tree set
// Pool size, node entry layout, status codes and the RAM request bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package bst_pkg;

  // Node pool size and derived widths
  localparam int POOL_NODES = 1024;
  localparam int IDX_W      = $clog2(POOL_NODES);
  localparam int CNT_W      = $clog2(POOL_NODES + 1);
  localparam int KEY_W      = 32;
  localparam int STAT_W     = 3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Result codes
  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

  // Operation selected by the mode bit
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // One node entry: key and both child links (link 0 means no child)
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    idx_t                    left;
    idx_t                    right;
  } node_t;

  // Request from the walker to the node RAM
  typedef struct packed {
    logic  we;
    idx_t  waddr;
    node_t wdata;
    idx_t  raddr;
  } ram_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/bst_node_ram.sv @@
// ----------------------------------------------------------------------------
// bst_node_ram: node pool storage
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bst_node_ram (
  input  wire logic              clk,
  input  wire bst_pkg::ram_req_t req,
  output bst_pkg::node_t         rd_data
);
  import bst_pkg::*;

  node_t mem [POOL_NODES];
  node_t rd_data_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ hw/rtl/bst_walker.sv @@
// ----------------------------------------------------------------------------
// bst_walker: tree walk sequencer
// Walks root to leaf one node read per cycle, links new nodes, reports status.
// ----------------------------------------------------------------------------
`default_nettype none

module bst_walker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_mode,
  input  wire logic signed [31:0]         in_key,
  output logic                            out_valid,
  output logic [bst_pkg::STAT_W-1:0]      out_status,
  output bst_pkg::ram_req_t               ram_req,
  input  wire bst_pkg::node_t             rd_data
);
  import bst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_NEW  = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  cnt_t                    used_r, used_nxt;
  idx_t                    cur_r, cur_nxt;
  logic                    mode_r, mode_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]       out_status_r, out_status_nxt;

  logic go_left;
  logic key_eq;
  idx_t next_idx;
  logic pool_full;
  node_t parent_upd;

  // Compare against the node just read and pick the child link
  assign go_left   = key_r < rd_data.key;
  assign key_eq    = key_r == rd_data.key;
  assign next_idx  = go_left ? rd_data.left : rd_data.right;
  assign pool_full = used_r == cnt_t'(POOL_NODES);

  // Parent entry with the new child linked in
  always_comb begin
    parent_upd = rd_data;
    if (go_left) begin
      parent_upd.left = used_r[IDX_W-1:0];
    end else begin
      parent_upd.right = used_r[IDX_W-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    cur_nxt        = cur_r;
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    ram_req.we     = 1'b0;
    ram_req.waddr  = cur_r;
    ram_req.wdata  = parent_upd;
    ram_req.raddr  = '0;

    case (state_r)
      S_IDLE: begin
        // root read issued here so its data is ready in S_CMP
        ram_req.raddr = '0;
        if (start) begin
          mode_nxt = in_mode;
          key_nxt  = in_key;
          cur_nxt  = '0;
          if (used_r == '0) begin
            if (in_mode == MODE_LOOKUP) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_NOT_FOUND;
            end else begin
              state_nxt = S_NEW;
            end
          end else begin
            state_nxt = S_CMP;
          end
        end
      end

      S_CMP: begin
        ram_req.raddr = next_idx;
        if (key_eq) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = (mode_r == MODE_LOOKUP) ? ST_FOUND : ST_DUPLICATE;
          state_nxt      = S_IDLE;
        end else if (next_idx == '0) begin
          if (mode_r == MODE_LOOKUP) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_NOT_FOUND;
            state_nxt      = S_IDLE;
          end else if (pool_full) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_FULL;
            state_nxt      = S_IDLE;
          end else begin
            // write back the parent with its new link, then make the node
            ram_req.we    = 1'b1;
            ram_req.waddr = cur_r;
            ram_req.wdata = parent_upd;
            state_nxt     = S_NEW;
          end
        end else begin
          // descend: the child read is already issued this cycle
          cur_nxt = next_idx;
        end
      end

      S_NEW: begin
        ram_req.we         = 1'b1;
        ram_req.waddr      = used_r[IDX_W-1:0];
        ram_req.wdata.key  = key_r;
        ram_req.wdata.left = '0;
        ram_req.wdata.right = '0;
        used_nxt           = used_r + cnt_t'(1);
        out_valid_nxt      = 1'b1;
        out_status_nxt     = ST_INSERTED;
        state_nxt          = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy       = state_r != S_IDLE;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

@@ hw/rtl/binary_search_tree_set_core.sv @@
// ----------------------------------------------------------------------------
// binary_search_tree_set_core: set of signed 32-bit keys in a node pool
// Insert or look up one key per command; one status strobe per command.
// ----------------------------------------------------------------------------
// A command transfers when start is high and busy is low. Its status appears
// on out_status for one cycle with out_valid high and cannot be held off, so
// capture it in that cycle. A command walks the tree one node RAM read per
// level; busy stays high while it compares nodes and, for an insert that links
// a node, while it writes that node. The strobe comes in the cycle in which
// busy falls. A lookup in an empty tree never raises busy; the first insert
// goes straight to writing its node. The next command can transfer in the
// strobe cycle. The node RAM needs no clearing pass after reset.
`default_nettype none

module binary_search_tree_set_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_mode,
  input  wire logic signed [31:0]    in_key,
  output logic                       out_valid,
  output logic [bst_pkg::STAT_W-1:0] out_status
);
  import bst_pkg::*;

  ram_req_t ram_req;
  node_t    rd_data;

  // Walk sequencer
  bst_walker u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_mode    (in_mode),
    .in_key     (in_key),
    .out_valid  (out_valid),
    .out_status (out_status),
    .ram_req    (ram_req),
    .rd_data    (rd_data)
  );

  // Node pool
  bst_node_ram u_node_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire
